>>> rtl/i2ew_pkg.sv
// Shared types and constants for the integer-to-English-words speller.
`default_nettype none
package i2ew_pkg;

   localparam int unsigned ValueW  = 31;
   localparam int unsigned WordW   = 5;
   localparam int unsigned GroupW  = 10;
   localparam int unsigned ScaleW  = 2;
   localparam int unsigned GrpSlots = 5;
   localparam int unsigned NumGroups = 4;
   localparam int unsigned NumSlots = GrpSlots * NumGroups;

   localparam logic [WordW-1:0] TOK_ZERO     = 5'd0;
   localparam logic [WordW-1:0] TOK_TENS_OFF = 5'd18;
   localparam logic [WordW-1:0] TOK_HUNDRED  = 5'd28;
   localparam logic [WordW-1:0] TOK_SCALE    = 5'd28;

   localparam logic [ScaleW-1:0] SCALE_NONE     = 2'd0;
   localparam logic [ScaleW-1:0] SCALE_THOUSAND = 2'd1;
   localparam logic [ScaleW-1:0] SCALE_MILLION  = 2'd2;
   localparam logic [ScaleW-1:0] SCALE_BILLION  = 2'd3;

   localparam logic [30:0] BILLION     = 31'd1000000000;
   localparam logic [30:0] TWO_BILLION = 31'd2000000000;
   localparam logic [19:0] MILLION     = 20'd1000000;
   localparam logic [9:0]  THOUSAND    = 10'd1000;

   // floor(2^50 / 10^6) and floor(2^30 / 10^3): quotient low by at most one
   localparam logic [30:0] RECIP_MILLION   = 31'd1125899906;
   localparam int unsigned ShiftMillion    = 50;
   localparam logic [20:0] RECIP_THOUSAND  = 21'd1073741;
   localparam int unsigned ShiftThousand   = 30;

   // exact for values below 1000 and below 100 respectively
   localparam logic [5:0]  RECIP_HUNDRED   = 6'd41;
   localparam int unsigned ShiftHundred    = 12;
   localparam logic [6:0]  RECIP_TEN       = 7'd103;
   localparam int unsigned ShiftTen        = 10;

   typedef struct packed {
      logic [GrpSlots-1:0][WordW-1:0] tok;
      logic [GrpSlots-1:0]            mask;
   } grp_words_type;

endpackage
`default_nettype wire

>>> rtl/i2ew_group.sv
// Three-digit group speller: hundreds, Hundred, tens or teen, ones, scale word.
`default_nettype none
module i2ew_group (
   input  wire logic [i2ew_pkg::GroupW-1:0] group_val,
   input  wire logic [i2ew_pkg::ScaleW-1:0] scale,
   output i2ew_pkg::grp_words_type          words
);

   logic [15:0] hund_prod;
   logic [3:0]  hund;
   logic [6:0]  rest;
   logic [13:0] ten_prod;
   logic [3:0]  tens;
   logic [3:0]  ones;
   logic        big;

   always_comb begin
      hund_prod = 16'(group_val) * 16'(i2ew_pkg::RECIP_HUNDRED);
      hund      = 4'(hund_prod >> i2ew_pkg::ShiftHundred);
      rest      = 7'(group_val - 10'(hund) * 10'd100);
      ten_prod  = 14'(rest) * 14'(i2ew_pkg::RECIP_TEN);
      tens      = 4'(ten_prod >> i2ew_pkg::ShiftTen);
      ones      = 4'(rest - 7'(tens) * 7'd10);
      big       = (rest >= 7'd20);

      words.tok[0] = 5'(hund);
      words.tok[1] = i2ew_pkg::TOK_HUNDRED;
      words.tok[2] = big ? (i2ew_pkg::TOK_TENS_OFF + 5'(tens)) : 5'(rest);
      words.tok[3] = 5'(ones);
      words.tok[4] = i2ew_pkg::TOK_SCALE + 5'(scale);

      words.mask[0] = (hund != 4'd0);
      words.mask[1] = (hund != 4'd0);
      words.mask[2] = (rest != 7'd0);
      words.mask[3] = big && (ones != 4'd0);
      words.mask[4] = (group_val != '0) && (scale != i2ew_pkg::SCALE_NONE);
   end

endmodule
`default_nettype wire

>>> rtl/integer_to_english_words.sv
// Top level: streams the English words of a 31-bit unsigned integer.
`default_nettype none
// A value taken on the req_ channel comes back on the rsp_ channel as its English
// words, one word token per transaction, rsp_tlast on the final one; zero gives the
// single token Zero. A six-stage pipeline splits the value into decimal groups
// (constant reciprocal multiplies with one correction step) and spells each group,
// then a token buffer hands the words out one per cycle while rsp_tready is high.
// The first token is shown on the rsp_ port once the value has left the sixth stage
// and been loaded into the token buffer. Each value gives 1 to 16 tokens on the
// single output port, and that port sets the sustained rate; the next value is
// taken while the previous one is still streaming, so with rsp_tready held high
// the words of consecutive values follow without gaps.
module integer_to_english_words (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [30:0] value, [31] zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [4:0] word, [7:5] zero
   output logic             rsp_tlast
);

   localparam int unsigned NS = i2ew_pkg::NumSlots;
   localparam int unsigned GS = i2ew_pkg::GrpSlots;
   localparam int unsigned WW = i2ew_pkg::WordW;

   logic [6:1] vld_ff, vld_in;
   logic       advance;

   logic [30:0] val_ff;
   logic [1:0]  b2_ff, b3_ff, b4_ff, b5_ff, b6_ff;
   logic [29:0] r2_ff, r3_ff;
   logic [10:0] q3_ff;
   logic [9:0]  m4_ff, m5_ff, m6_ff;
   logic [19:0] r4_ff, r5_ff;
   logic [9:0]  q5_ff;
   logic [9:0]  k6_ff, u6_ff;

   logic [30:0] bill_sub;
   logic [1:0]  b2_in;
   logic [29:0] r2_in;
   logic [60:0] prod_m;
   logic [30:0] rem_m_full;
   logic [20:0] rem_m;
   logic [9:0]  m4_in;
   logic [19:0] r4_in;
   logic [40:0] prod_k;
   logic [19:0] rem_k_full;
   logic [10:0] rem_k;
   logic [9:0]  k6_in, u6_in;

   i2ew_pkg::grp_words_type gw [i2ew_pkg::NumGroups];

   logic [NS-1:0][WW-1:0] tok_ff, tok_in, new_tok;
   logic [NS-1:0]         mask_ff, mask_in, new_mask, low_bit;
   logic                  pop, is_last, load;
   logic [WW-1:0]         cur_word;

   // billions group by compare and subtract
   always_comb begin
      priority if (val_ff >= i2ew_pkg::TWO_BILLION) begin
         b2_in    = 2'd2;
         bill_sub = i2ew_pkg::TWO_BILLION;
      end else if (val_ff >= i2ew_pkg::BILLION) begin
         b2_in    = 2'd1;
         bill_sub = i2ew_pkg::BILLION;
      end else begin
         b2_in    = 2'd0;
         bill_sub = '0;
      end
      r2_in = 30'(val_ff - bill_sub);
   end

   // millions group: estimate, then remainder and correction
   always_comb begin
      prod_m     = 61'(r2_ff) * 61'(i2ew_pkg::RECIP_MILLION);
      rem_m_full = 31'(r3_ff) - 31'(q3_ff) * 31'(i2ew_pkg::MILLION);
      rem_m      = 21'(rem_m_full);
      if (rem_m >= 21'(i2ew_pkg::MILLION)) begin
         m4_in = 10'(q3_ff + 11'd1);
         r4_in = 20'(rem_m - 21'(i2ew_pkg::MILLION));
      end else begin
         m4_in = 10'(q3_ff);
         r4_in = 20'(rem_m);
      end
   end

   // thousands and units groups
   always_comb begin
      prod_k     = 41'(r4_ff) * 41'(i2ew_pkg::RECIP_THOUSAND);
      rem_k_full = r5_ff - 20'(q5_ff) * 20'(i2ew_pkg::THOUSAND);
      rem_k      = 11'(rem_k_full);
      if (rem_k >= 11'(i2ew_pkg::THOUSAND)) begin
         k6_in = 10'(q5_ff + 10'd1);
         u6_in = 10'(rem_k - 11'(i2ew_pkg::THOUSAND));
      end else begin
         k6_in = q5_ff;
         u6_in = 10'(rem_k);
      end
   end

   i2ew_group u_grp_bil (.group_val(10'(b6_ff)), .scale(i2ew_pkg::SCALE_BILLION),
                         .words(gw[0]));
   i2ew_group u_grp_mil (.group_val(m6_ff), .scale(i2ew_pkg::SCALE_MILLION),
                         .words(gw[1]));
   i2ew_group u_grp_tho (.group_val(k6_ff), .scale(i2ew_pkg::SCALE_THOUSAND),
                         .words(gw[2]));
   i2ew_group u_grp_one (.group_val(u6_ff), .scale(i2ew_pkg::SCALE_NONE),
                         .words(gw[3]));

   always_comb begin
      for (int g = 0; g < int'(i2ew_pkg::NumGroups); g++) begin
         for (int s = 0; s < int'(GS); s++) begin
            new_tok[g*GS+s]  = gw[g].tok[s];
            new_mask[g*GS+s] = gw[g].mask[s];
         end
      end
      if (new_mask == '0) begin
         new_tok[0]  = i2ew_pkg::TOK_ZERO;
         new_mask[0] = 1'b1;
      end
   end

   // token buffer: emit the lowest pending slot each cycle that rsp_tready is high
   always_comb begin
      low_bit  = mask_ff & (~mask_ff + NS'(1));
      cur_word = '0;
      for (int i = 0; i < int'(NS); i++) begin
         if (low_bit[i]) begin
            cur_word = cur_word | tok_ff[i];
         end
      end
      is_last = ((mask_ff & ~low_bit) == '0);
      pop     = rsp_tvalid && rsp_tready;
      load    = vld_ff[6] && ((mask_ff == '0) || (pop && is_last));
      advance = !vld_ff[6] || load;

      tok_in = load ? new_tok : tok_ff;
      if (load) begin
         mask_in = new_mask;
      end else if (pop) begin
         mask_in = mask_ff & ~low_bit;
      end else begin
         mask_in = mask_ff;
      end

      vld_in = advance ? {vld_ff[5:1], req_tvalid} : vld_ff;
   end

   assign req_tready = advance;
   assign rsp_tvalid = (mask_ff != '0);
   assign rsp_tdata  = 8'(cur_word);
   assign rsp_tlast  = is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         mask_ff <= '0;
      end else begin
         vld_ff  <= vld_in;
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
      if (advance) begin
         val_ff <= req_tdata[30:0];
         b2_ff  <= b2_in;
         r2_ff  <= r2_in;
         b3_ff  <= b2_ff;
         r3_ff  <= r2_ff;
         q3_ff  <= 11'(prod_m >> i2ew_pkg::ShiftMillion);
         b4_ff  <= b3_ff;
         m4_ff  <= m4_in;
         r4_ff  <= r4_in;
         b5_ff  <= b4_ff;
         m5_ff  <= m4_ff;
         r5_ff  <= r4_ff;
         q5_ff  <= 10'(prod_k >> i2ew_pkg::ShiftThousand);
         b6_ff  <= b5_ff;
         m6_ff  <= m5_ff;
         k6_ff  <= k6_in;
         u6_ff  <= u6_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/i2ew_check.sv
// Port checker for the word speller and its bind to the top level.
`default_nettype none
module i2ew_check (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [31:0] req_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata,
   input wire logic        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled transaction changed");

   a_zero_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4:0] == i2ew_pkg::TOK_ZERO |-> rsp_tlast)
      else $error("Zero token not alone");

   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata))
      else $error("stalled request changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid after reset");

endmodule

bind integer_to_english_words i2ew_check u_i2ew_check (
   .clock(clock),
   .reset(reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .req_tdata(req_tdata),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata),
   .rsp_tlast(rsp_tlast)
);
`default_nettype wire
